/* rtl/core/cdq_pkg.sv */
// shared types and constants for the circular deque
package cdq_pkg;

  // item payload width
  localparam int DATA_W    = 32;
  // default number of store entries
  localparam int DEPTH_DEF = 8;

  // requested action codes
  typedef enum logic [1:0] {
    ACT_PUSH_FRONT = 2'd0,
    ACT_PUSH_REAR  = 2'd1,
    ACT_POP_FRONT  = 2'd2,
    ACT_POP_REAR   = 2'd3
  } action_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_t;

endpackage

/* rtl/core/cdq_store.sv */
// element store: one write port, one registered read port
module cdq_store
  import cdq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [AW-1:0]            wr_addr,
  input  logic signed [DATA_W-1:0] wr_data,
  input  logic                     rd_en,
  input  logic [AW-1:0]            rd_addr,
  output logic signed [DATA_W-1:0] rd_data
);

  logic signed [DATA_W-1:0] mem [DEPTH];
  logic signed [DATA_W-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, registered: data follows the address in the next cycle
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* rtl/core/circular_deque_top.sv */
// circular deque top level: pointer control around the element store
//
//  channel  | ports                                          | handshake
//  ---------+------------------------------------------------+--------------------------
//  input    | in_action, in_push_value                       | start high, busy low
//  result   | out_popped_value, out_status, out_now_empty,   | out_valid, one cycle,
//           | out_now_full                                   | no back-pressure
//
// for each item, the accept edge updates the pointers and issues the store
// write or read, and the result strobes on the next cycle once the store read
// data is back. busy is high during that result cycle, so no new item is taken
// while a result strobes. reset clears the pointers and marks the deque empty;
// the store needs no clearing. the receiver cannot stall the result.
module circular_deque_top
  import cdq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [1:0]               in_action,
  input  logic signed [DATA_W-1:0] in_push_value,
  output logic                     out_valid,
  output logic signed [DATA_W-1:0] out_popped_value,
  output logic [1:0]               out_status,
  output logic                     out_now_empty,
  output logic                     out_now_full
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  logic [AW-1:0] front_r, front_nxt;
  logic [AW-1:0] rear_r, rear_nxt;
  logic          empty_r, empty_nxt;
  logic          pend_r;
  logic          pop_ok_r, pop_ok_nxt;
  status_t       status_r, status_nxt;
  logic          full_r, full_nxt;

  logic          accept;
  logic          full_now;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic signed [DATA_W-1:0] rd_data;
  action_t       act;

  // wrapping pointer steps
  function automatic logic [AW-1:0] step_up(input logic [AW-1:0] p);
    return (p >= LAST) ? '0 : p + AW'(1);
  endfunction

  function automatic logic [AW-1:0] step_down(input logic [AW-1:0] p);
    return (p == '0 || p > LAST) ? LAST : p - AW'(1);
  endfunction

  assign accept   = start && !busy;
  assign busy     = pend_r;
  assign act      = action_t'(in_action);
  assign full_now = !empty_r && (front_r == step_up(rear_r));

  // action decode: pointer update, store access, result fields
  always_comb begin
    front_nxt  = front_r;
    rear_nxt   = rear_r;
    empty_nxt  = empty_r;
    status_nxt = ST_DONE;
    pop_ok_nxt = 1'b0;
    wr_en      = 1'b0;
    wr_addr    = '0;
    rd_en      = 1'b0;
    rd_addr    = front_r;
    unique case (act)
      ACT_PUSH_FRONT, ACT_PUSH_REAR: begin
        if (full_now) begin
          status_nxt = ST_OVERFLOW;
        end else if (empty_r) begin
          front_nxt = '0;
          rear_nxt  = '0;
          empty_nxt = 1'b0;
          wr_en     = accept;
          wr_addr   = '0;
        end else if (act == ACT_PUSH_FRONT) begin
          front_nxt = step_down(front_r);
          wr_en     = accept;
          wr_addr   = front_nxt;
        end else begin
          rear_nxt = step_up(rear_r);
          wr_en    = accept;
          wr_addr  = rear_nxt;
        end
      end
      ACT_POP_FRONT, ACT_POP_REAR: begin
        if (empty_r) begin
          status_nxt = ST_UNDERFLOW;
        end else begin
          pop_ok_nxt = 1'b1;
          rd_en      = accept;
          rd_addr    = (act == ACT_POP_FRONT) ? front_r : rear_r;
          if (front_r == rear_r) begin
            front_nxt = '0;
            rear_nxt  = '0;
            empty_nxt = 1'b1;
          end else if (act == ACT_POP_FRONT) begin
            front_nxt = step_up(front_r);
          end else begin
            rear_nxt = step_down(rear_r);
          end
        end
      end
      default: begin
        status_nxt = ST_DONE;
      end
    endcase
    full_nxt = !empty_nxt && (front_nxt == step_up(rear_nxt));
  end

  // pointer and flag registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r <= '0;
      rear_r  <= '0;
      empty_r <= 1'b1;
      pend_r  <= 1'b0;
    end else begin
      pend_r <= accept;
      if (accept) begin
        front_r <= front_nxt;
        rear_r  <= rear_nxt;
        empty_r <= empty_nxt;
      end
    end
  end

  // result fields held for the strobe cycle
  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= status_nxt;
      pop_ok_r <= pop_ok_nxt;
      full_r   <= full_nxt;
    end
  end

  cdq_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (in_push_value),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // result outputs
  assign out_valid        = pend_r;
  assign out_popped_value = pop_ok_r ? rd_data : '0;
  assign out_status       = status_r;
  assign out_now_empty    = empty_r;
  assign out_now_full     = full_r;

endmodule

/* test/testbench.sv */
// self-checking testbench for the circular deque: directed and random actions
module testbench;
  import cdq_pkg::*;

  localparam int DEPTH       = DEPTH_DEF;
  localparam int RANDOM_ITEMS = 1450;
  localparam int STALL_LIMIT = 2000;
  localparam int MAX_REPORTS = 10;

  // one predicted result item
  typedef struct {
    logic [DATA_W-1:0] popped;
    status_t           status;
    logic              now_empty;
    logic              now_full;
  } deque_result_t;

  // deque predictor plus the queue of results still owed by the block
  class deque_scoreboard;
    logic [DATA_W-1:0] slot_mem [DEPTH];
    int unsigned       head_idx;
    int unsigned       tail_idx;
    bit                is_empty;
    deque_result_t     pending_results[$];
    int                mismatch_count;

    function new();
      head_idx       = 0;
      tail_idx       = 0;
      is_empty       = 1'b1;
      mismatch_count = 0;
    endfunction

    function int unsigned wrap_up(int unsigned i);
      return (i >= DEPTH - 1) ? 0 : i + 1;
    endfunction

    function int unsigned wrap_down(int unsigned i);
      return (i == 0) ? DEPTH - 1 : i - 1;
    endfunction

    function bit holds_depth();
      return !is_empty && head_idx == wrap_up(tail_idx);
    endfunction

    // apply one accepted action and queue the result it must produce
    function void note_action(action_t act, logic [DATA_W-1:0] val);
      deque_result_t res;
      res.popped = '0;
      res.status = ST_DONE;
      if (act == ACT_PUSH_FRONT || act == ACT_PUSH_REAR) begin
        if (holds_depth()) begin
          res.status = ST_OVERFLOW;
        end else if (is_empty) begin
          // first element always lands in slot zero
          head_idx    = 0;
          tail_idx    = 0;
          is_empty    = 1'b0;
          slot_mem[0] = val;
        end else if (act == ACT_PUSH_FRONT) begin
          head_idx           = wrap_down(head_idx);
          slot_mem[head_idx] = val;
        end else begin
          tail_idx           = wrap_up(tail_idx);
          slot_mem[tail_idx] = val;
        end
      end else begin
        if (is_empty) begin
          res.status = ST_UNDERFLOW;
        end else begin
          res.popped = (act == ACT_POP_FRONT) ? slot_mem[head_idx] : slot_mem[tail_idx];
          // last element out resets both pointers
          if (head_idx == tail_idx) begin
            head_idx = 0;
            tail_idx = 0;
            is_empty = 1'b1;
          end else if (act == ACT_POP_FRONT) begin
            head_idx = wrap_up(head_idx);
          end else begin
            tail_idx = wrap_down(tail_idx);
          end
        end
      end
      res.now_empty = is_empty;
      res.now_full  = holds_depth();
      pending_results.push_back(res);
    endfunction

    // compare one strobed result with the oldest prediction
    function void check_result(logic [DATA_W-1:0] popped, logic [1:0] status,
                               logic now_empty, logic now_full);
      deque_result_t want;
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("unexpected result: popped=%h status=%0d empty=%b full=%b",
                   popped, status, now_empty, now_full);
        return;
      end
      want = pending_results.pop_front();
      if (popped !== want.popped || status !== want.status ||
          now_empty !== want.now_empty || now_full !== want.now_full) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display({"result mismatch: expected popped=%h status=%0d empty=%b full=%b,",
                    " got popped=%h status=%0d empty=%b full=%b"},
                   want.popped, want.status, want.now_empty, want.now_full,
                   popped, status, now_empty, now_full);
      end
    endfunction
  endclass

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     start = 1'b0;
  logic                     busy;
  logic [1:0]               in_action = ACT_PUSH_FRONT;
  logic signed [DATA_W-1:0] in_push_value = '0;
  logic                     out_valid;
  logic signed [DATA_W-1:0] out_popped_value;
  logic [1:0]               out_status;
  logic                     out_now_empty;
  logic                     out_now_full;

  deque_scoreboard sb = new();
  int              idle_cycles = 0;

  circular_deque_top #(.DEPTH(DEPTH)) u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_action        (in_action),
    .in_push_value    (in_push_value),
    .out_valid        (out_valid),
    .out_popped_value (out_popped_value),
    .out_status       (out_status),
    .out_now_empty    (out_now_empty),
    .out_now_full     (out_now_full)
  );

  // clock
  always #6 clk = ~clk;

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1)
      sb.check_result(out_popped_value, out_status, out_now_empty, out_now_full);
  end

  // watchdog on cycles where neither side moves an item
  always @(posedge clk) begin
    if ((start === 1'b1 && busy === 1'b0) || out_valid === 1'b1)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  // present one item after an optional gap and hold it until taken
  task automatic issue_action(action_t act, logic [DATA_W-1:0] val, int gap);
    @(negedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start         <= 1'b1;
    in_action     <= act;
    in_push_value <= val;
    forever begin
      @(posedge clk);
      if (busy === 1'b0) break;
    end
    sb.note_action(act, val);
  endtask

  // stop sending until every owed result has come back
  task automatic wait_drained();
    @(negedge clk);
    start <= 1'b0;
    while (sb.pending_results.size() != 0) @(negedge clk);
  endtask

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // corner values mixed into random data
  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  // stimulus
  initial begin
    logic [DATA_W-1:0] fill_vals [8];
    int                random_sent;
    int                phase_len;
    int                mode;
    bit                no_gaps;
    action_t           act;

    fill_vals = '{32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000, 32'hffff_ffff,
                  32'h5555_5555, 32'haaaa_aaaa, 32'h0000_0001, 32'hfffffffe};
    random_sent = 0;

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // underflow on both ends of an empty deque
    issue_action(ACT_POP_FRONT, 32'hdead_beef, 0);
    issue_action(ACT_POP_REAR, 32'h1234_5678, 0);
    // single element in and out from opposite ends
    issue_action(ACT_PUSH_FRONT, 32'h8000_0000, 0);
    issue_action(ACT_POP_REAR, 32'h0, 0);
    issue_action(ACT_PUSH_REAR, 32'h7fff_ffff, 1);
    issue_action(ACT_POP_FRONT, 32'hffff_ffff, 0);
    // fill to depth from both ends, front pushes wrap below slot zero
    for (int i = 0; i < DEPTH; i++)
      issue_action((i % 2) ? ACT_PUSH_REAR : ACT_PUSH_FRONT, fill_vals[i % 8], 0);
    // overflow on both ends
    issue_action(ACT_PUSH_FRONT, 32'h0bad_0bad, 0);
    issue_action(ACT_PUSH_REAR, 32'h0bad_0bad, 0);
    // drain from both ends past empty
    for (int i = 0; i < DEPTH; i++)
      issue_action((i % 2) ? ACT_POP_REAR : ACT_POP_FRONT, $urandom, 0);
    issue_action(ACT_POP_FRONT, 32'h0, 0);
    wait_drained();

    // random phases biased toward filling, draining or mixing
    while (random_sent < RANDOM_ITEMS) begin
      phase_len = $urandom_range(20, 60);
      mode      = $urandom_range(0, 2);
      no_gaps   = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < phase_len && random_sent < RANDOM_ITEMS; i++) begin
        case (mode)
          0: act = ($urandom_range(0, 99) < 80) ? action_t'($urandom_range(0, 1))
                                                : action_t'($urandom_range(2, 3));
          1: act = ($urandom_range(0, 99) < 80) ? action_t'($urandom_range(2, 3))
                                                : action_t'($urandom_range(0, 1));
          default: act = action_t'($urandom_range(0, 3));
        endcase
        issue_action(act, pick_value(), no_gaps ? 0 : pick_gap());
        random_sent++;
        if (random_sent % 300 == 0) wait_drained();
      end
    end

    wait_drained();
    repeat (4) @(negedge clk);
    if (sb.mismatch_count == 0 && sb.pending_results.size() == 0)
      $display("testbench: PASS");
    else
      $display("testbench: FAIL");
    $finish;
  end

endmodule
